### rtl/core/lss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared widths, opcodes, result codes and the control/status bundles
// between the stack controller and datapath.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int OP_W  = 2;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;
  localparam int POS_W = 7;

  localparam logic [OP_W-1:0] OP_PUSH     = 2'd0;
  localparam logic [OP_W-1:0] OP_POP      = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH   = 2'd2;
  localparam logic [OP_W-1:0] OP_TRAVERSE = 2'd3;

  localparam logic [ST_W-1:0] ST_PUSHED      = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL        = 3'd1;
  localparam logic [ST_W-1:0] ST_POPPED      = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY       = 3'd3;
  localparam logic [ST_W-1:0] ST_FOUND       = 3'd4;
  localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd5;
  localparam logic [ST_W-1:0] ST_ELEMENT     = 3'd6;
  localparam logic [ST_W-1:0] ST_STORE_EMPTY = 3'd7;

  // Source of the result word
  localparam logic [1:0] VSEL_ZERO = 2'd0;
  localparam logic [1:0] VSEL_KEY  = 2'd1;
  localparam logic [1:0] VSEL_RAM  = 2'd2;

  typedef struct packed {
    logic            load;    // capture request, arm the walk pointer
    logic            step;    // advance walk one entry toward the bottom
    logic            wr;      // write the key on top, bump count
    logic            dec;     // drop the top entry
    logic            emit;    // register a result
    logic [ST_W-1:0] code;
    logic [1:0]      vsel;
    logic            pos_en;
    logic            last;
  } lss_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            match;
    logic            at_last;
  } lss_stat_t;

endpackage

### rtl/core/lss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/lss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_datapath
// Entry store, count, walk pointer and position, key compare and the
// registered result port.
// ----------------------------------------------------------------------------
module lss_datapath import lss_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [OP_W-1:0]         opcode,
  input  logic signed [VAL_W-1:0] operand_value,
  input  lss_cmd_t                cmd,
  output lss_stat_t               stat,
  output logic                    done,
  output logic [ST_W-1:0]         status,
  output logic signed [VAL_W-1:0] result_value,
  output logic [POS_W-1:0]        position,
  output logic                    last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_dec;
  logic [AW-1:0]    ptr;
  logic [AW-1:0]    ptr_dec;
  logic [AW-1:0]    raddr;
  logic [CW-1:0]    pos;
  logic [VAL_W-1:0] key;
  logic [OP_W-1:0]  op;
  logic [VAL_W-1:0] rdata;

  assign count_dec = count - 1'b1;
  assign ptr_dec   = ptr - 1'b1;
  // Look one entry ahead while stepping so the walk reads every cycle
  assign raddr     = cmd.step ? ptr_dec : ptr;

  lss_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (count[AW-1:0]),
    .wdata (key),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr) begin
      count <= count + 1'b1;
    end else if (cmd.dec) begin
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= operand_value;
      op  <= opcode;
      ptr <= count_dec[AW-1:0];
      pos <= CW'(1);
    end else if (cmd.step) begin
      ptr <= ptr_dec;
      pos <= pos + 1'b1;
    end
  end

  assign stat.op      = op;
  assign stat.empty   = (count == '0);
  assign stat.full    = (count == CW'(DEPTH));
  assign stat.match   = (rdata == key);
  assign stat.at_last = (pos == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status   <= cmd.code;
      last     <= cmd.last;
      position <= cmd.pos_en ? POS_W'(pos) : '0;
      unique case (cmd.vsel)
        VSEL_KEY: result_value <= key;
        VSEL_RAM: result_value <= rdata;
        default:  result_value <= '0;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.dec |-> count != '0)
    else $error("pop issued on empty store");

  a_wr_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> count != CW'(DEPTH))
    else $error("push written into full store");

  a_walk_contig: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done)
    else $error("gap inside a multi-result request");

endmodule

### rtl/core/lss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ctrl
// Request sequencer: dispatch on the opcode, run the search and
// traverse walks, and pick each result's code and sources.
// ----------------------------------------------------------------------------
module lss_ctrl import lss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  lss_stat_t stat,
  output lss_cmd_t  cmd,
  output logic      busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.last   = 1'b1;
    cmd.vsel   = VSEL_ZERO;
    cmd.code   = ST_PUSHED;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_IDLE;
        unique case (stat.op)
          OP_PUSH: begin
            cmd.emit = 1'b1;
            if (stat.full) begin
              cmd.code = ST_FULL;
            end else begin
              cmd.wr   = 1'b1;
              cmd.code = ST_PUSHED;
            end
          end
          OP_POP: begin
            if (stat.empty) begin
              cmd.emit = 1'b1;
              cmd.code = ST_EMPTY;
            end else begin
              // top entry read is already in flight
              cmd.dec    = 1'b1;
              state_next = S_POP;
            end
          end
          OP_SEARCH: begin
            if (stat.empty) begin
              cmd.emit = 1'b1;
              cmd.code = ST_NOT_FOUND;
              cmd.vsel = VSEL_KEY;
            end else begin
              state_next = S_SCAN;
            end
          end
          default: begin
            if (stat.empty) begin
              cmd.emit = 1'b1;
              cmd.code = ST_STORE_EMPTY;
            end else begin
              state_next = S_WALK;
            end
          end
        endcase
      end
      S_POP: begin
        cmd.emit   = 1'b1;
        cmd.code   = ST_POPPED;
        cmd.vsel   = VSEL_RAM;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.vsel = VSEL_KEY;
        priority if (stat.match) begin
          cmd.emit   = 1'b1;
          cmd.code   = ST_FOUND;
          cmd.pos_en = 1'b1;
          state_next = S_IDLE;
        end else if (stat.at_last) begin
          cmd.emit   = 1'b1;
          cmd.code   = ST_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_WALK: begin
        cmd.emit   = 1'b1;
        cmd.code   = ST_ELEMENT;
        cmd.vsel   = VSEL_RAM;
        cmd.pos_en = 1'b1;
        cmd.last   = stat.at_last;
        if (stat.at_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/lifo_stack_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded LIFO of 32-bit words with linear search and top-to-bottom walk.
// A request is captured in idle and decoded in dispatch. Push, full and
// empty-store results come from dispatch, pop from a read state, search
// from a scan to a hit or the bottom; traverse strobes one entry per cycle.
// A new request is taken in the cycle its last result is on the ports.
// Synchronous reset empties the store; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module lifo_stack_with_search import lss_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         opcode,
  input  logic signed [VAL_W-1:0] operand_value,
  output logic                    done,
  output logic [ST_W-1:0]         status,
  output logic signed [VAL_W-1:0] result_value,
  output logic [POS_W-1:0]        position,
  output logic                    last
);

  lss_cmd_t  cmd;
  lss_stat_t stat;

  lss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lss_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .opcode        (opcode),
    .operand_value (operand_value),
    .cmd           (cmd),
    .stat          (stat),
    .done          (done),
    .status        (status),
    .result_value  (result_value),
    .position      (position),
    .last          (last)
  );

endmodule

### dv/tb_lifo_stack_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_search
// Self-checking bench for the bounded LIFO with search and walk. Requests go
// in on the start/busy handshake. A mirror of the stack predicts every
// strobed result. Results are checked in order, field by field. The run has a
// short directed part, then fill, drain and mixed random segments under
// varying sender gaps.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_search;
  import lss_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [ST_W-1:0]         code;
    logic signed [VAL_W-1:0] word;
    logic [POS_W-1:0]        pos;
    logic                    fin;
  } stack_result_t;

  // Mirror of the stack contents plus the queue of results still owed.
  class lifo_mirror;
    logic signed [VAL_W-1:0] words [STACK_DEPTH];
    int unsigned             fill;
    stack_result_t           owed_results [$];
    int unsigned             errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
    endtask

    function int unsigned outstanding();
      return owed_results.size();
    endfunction

    // Any word currently held; used to aim searches at hits.
    function logic signed [VAL_W-1:0] held_word();
      return words[$urandom_range(fill - 1)];
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] key);
      stack_result_t r;
      int unsigned   i;
      r.code = ST_PUSHED;
      r.word = '0;
      r.pos  = '0;
      r.fin  = 1'b1;
      case (op)
        OP_PUSH: begin
          if (fill == STACK_DEPTH) begin
            r.code = ST_FULL;
          end else begin
            words[fill] = key;
            fill++;
          end
          owed_results.push_back(r);
        end
        OP_POP: begin
          if (fill == 0) begin
            r.code = ST_EMPTY;
          end else begin
            fill--;
            r.code = ST_POPPED;
            r.word = words[fill];
          end
          owed_results.push_back(r);
        end
        OP_SEARCH: begin
          r.code = ST_NOT_FOUND;
          r.word = key;
          // first hit counted from the top wins
          for (i = 0; i < fill && r.code != ST_FOUND; i++) begin
            if (words[fill - 1 - i] == key) begin
              r.code = ST_FOUND;
              r.pos  = POS_W'(i + 1);
            end
          end
          owed_results.push_back(r);
        end
        default: begin
          if (fill == 0) begin
            r.code = ST_STORE_EMPTY;
            owed_results.push_back(r);
          end else begin
            for (i = 0; i < fill; i++) begin
              r.code = ST_ELEMENT;
              r.word = words[fill - 1 - i];
              r.pos  = POS_W'(i + 1);
              r.fin  = (i + 1 == fill);
              owed_results.push_back(r);
            end
          end
        end
      endcase
    endfunction

    task check_result(logic [ST_W-1:0] got_code, logic signed [VAL_W-1:0] got_word,
                      logic [POS_W-1:0] got_pos, logic got_fin);
      stack_result_t e;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result status %0d value %0d", got_code, got_word));
        return;
      end
      e = owed_results.pop_front();
      if (got_code !== e.code)
        report($sformatf("status exp %0d got %0d", e.code, got_code));
      if (got_word !== e.word)
        report($sformatf("result_value exp %0d got %0d (status %0d)", e.word, got_word, e.code));
      if (got_pos !== e.pos)
        report($sformatf("position exp %0d got %0d (status %0d)", e.pos, got_pos, e.code));
      if (got_fin !== e.fin)
        report($sformatf("last exp %0b got %0b (status %0d)", e.fin, got_fin, e.code));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [OP_W-1:0]         opcode;
  logic signed [VAL_W-1:0] operand_value;
  logic                    done;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] result_value;
  logic [POS_W-1:0]        position;
  logic                    last;

  lifo_mirror                mirror;
  int unsigned               sender_idle_pct;
  int unsigned               cycle_count;

  lifo_stack_with_search #(.DEPTH(STACK_DEPTH)) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .operand_value(operand_value),
    .done         (done),
    .status       (status),
    .result_value (result_value),
    .position     (position),
    .last         (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) mirror.check_result(status, result_value, position, last);
  end

  // Drive one request and hold it until the block takes it.
  task automatic send_request(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    opcode        <= op;
    operand_value <= val;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    mirror.note_request(op, val);
  endtask

  // Mix of extremes, a small pool for duplicates, and full-range words.
  function automatic logic signed [VAL_W-1:0] random_word();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return '0;
        default: return -1;
      endcase
    end
    if (pick <= 3) return VAL_W'($urandom_range(7));
    return $urandom;
  endfunction

  initial begin
    int unsigned             n;
    int unsigned             mode;
    int unsigned             roll;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] val;

    mirror          = new();
    cycle_count     = 0;
    sender_idle_pct = 23;
    rst             = 1'b1;
    start           = 1'b0;
    opcode          = OP_PUSH;
    operand_value   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty-store cases first, then extremes and duplicates.
    send_request(OP_TRAVERSE, 32'sh1234_5678);
    send_request(OP_POP, -1);
    send_request(OP_SEARCH, '0);
    send_request(OP_PUSH, 32'sh8000_0000);
    send_request(OP_PUSH, 32'sh7FFF_FFFF);
    send_request(OP_PUSH, '0);
    send_request(OP_PUSH, -1);
    send_request(OP_PUSH, 32'sh5555_5555);
    send_request(OP_PUSH, 32'shAAAA_AAAA);
    send_request(OP_PUSH, 32'sh7FFF_FFFF);
    send_request(OP_SEARCH, 32'sh7FFF_FFFF);
    send_request(OP_SEARCH, 32'sh8000_0000);
    send_request(OP_SEARCH, 32'sh0001_2345);
    send_request(OP_SEARCH, '0);
    send_request(OP_TRAVERSE, '0);
    send_request(OP_POP, '0);
    send_request(OP_POP, 32'sh7FFF_FFFF);
    send_request(OP_SEARCH, 32'sh7FFF_FFFF);
    send_request(OP_SEARCH, -1);
    send_request(OP_TRAVERSE, -1);

    // Segments: fill past full, drain past empty, mixed, fill again.
    for (n = 0; n < 330; n++) begin
      if (n < 110) sender_idle_pct = 23;
      else if (n < 220) sender_idle_pct = 49;
      else sender_idle_pct = 0;
      if (n < 90) mode = 0;
      else if (n < 180) mode = 1;
      else if (n < 255) mode = 2;
      else mode = 0;
      roll = $urandom_range(99);
      case (mode)
        0: op = (roll < 80) ? OP_PUSH : (roll < 85) ? OP_POP :
                (roll < 95) ? OP_SEARCH : OP_TRAVERSE;
        1: op = (roll < 75) ? OP_POP : (roll < 85) ? OP_PUSH :
                (roll < 95) ? OP_SEARCH : OP_TRAVERSE;
        default: op = (roll < 35) ? OP_PUSH : (roll < 65) ? OP_POP :
                      (roll < 90) ? OP_SEARCH : OP_TRAVERSE;
      endcase
      if (op == OP_SEARCH && mirror.fill != 0 && $urandom_range(99) < 60)
        val = mirror.held_word();
      else
        val = random_word();
      send_request(op, val);
    end

    @(negedge clk);
    start <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mirror.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
